@@ sv/pixel_histogram_threshold_core_defines.svh @@
// assertion macros for the pixel histogram threshold core
// expects clk and arst_n in the scope of the module that uses them
`ifndef PIXEL_HISTOGRAM_THRESHOLD_CORE_DEFINES_SVH
`define PIXEL_HISTOGRAM_THRESHOLD_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PHT_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define PHT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/phtc_pkg.sv @@
// shared types and constants for the pixel histogram threshold core
// no dependencies
package phtc_pkg;

	localparam int CMD_BITS       = 2;
	localparam int VALUE_BITS     = 8;
	localparam int CFG_BITS       = 8;
	localparam int CFG_IDX_BITS   = 2;
	localparam int COUNT_OUT_BITS = 20;
	localparam int BAR_BITS       = 8;
	localparam int OUT_DATA_BITS  = 32;

	typedef logic [CMD_BITS-1:0]     cmd_t;
	typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

	// command codes
	localparam cmd_t CMD_ACCUM = 2'd0;
	localparam cmd_t CMD_READ  = 2'd1;
	localparam cmd_t CMD_CLEAR = 2'd2;

	// register indexes
	localparam cfg_idx_t CFG_THRESHOLD = 2'd0;
	localparam cfg_idx_t CFG_MAX_VALUE = 2'd1;
	localparam cfg_idx_t CFG_BAR_CAP   = 2'd2;

	// register reset values
	localparam logic [CFG_BITS-1:0] THRESHOLD_RST = 8'd128;
	localparam logic [CFG_BITS-1:0] MAX_VALUE_RST = 8'd255;
	localparam logic [CFG_BITS-1:0] BAR_CAP_RST   = 8'd60;

	typedef struct packed {
		logic                      out_of_range;
		logic [BAR_BITS-1:0]       bar_length;
		logic [COUNT_OUT_BITS-1:0] bin_count;
		logic                      binary_pixel;
	} result_t;

endpackage

@@ sv/pixel_histogram_threshold_core.sv @@
// pixel histogram threshold core: the bin is read at accept into stage 1, then the
// result is registered; throughput one item per cycle unless the receiver stalls;
// the bin is written back as the item leaves stage 1, with the last write forwarded
// when the same bin follows; asynchronous reset clears registers, then a sweep
// zeroes every bin while s_axis_tready stays low (config writes are still taken)
`include "pixel_histogram_threshold_core_defines.svh"

module pixel_histogram_threshold_core #(
	parameter int PIXEL_BITS = 8,
	parameter int COUNT_BITS = 20
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// input items
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [phtc_pkg::VALUE_BITS-1:0]       s_axis_tdata,  // [7:0] value
	input  logic [phtc_pkg::CMD_BITS-1:0]         s_axis_tuser,  // [1:0] cmd
	// result items
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// [0] binary_pixel, [20:1] bin_count, [28:21] bar_length, [31:29] zero
	output logic [phtc_pkg::OUT_DATA_BITS-1:0]    m_axis_tdata,
	output logic                                  m_axis_tuser,  // [0] out_of_range
	// register writes
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [phtc_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [phtc_pkg::CFG_BITS-1:0]         cfg_data
);

	localparam int NUM_BINS = 2 ** PIXEL_BITS;
	localparam int IDX_WIDE = PIXEL_BITS + phtc_pkg::VALUE_BITS;
	localparam int CNT_WIDE = COUNT_BITS + phtc_pkg::COUNT_OUT_BITS;

	// configuration registers
	logic [phtc_pkg::CFG_BITS-1:0] threshold_q;
	logic [phtc_pkg::CFG_BITS-1:0] max_value_q;
	logic [phtc_pkg::CFG_BITS-1:0] bar_cap_q;

	// clearing sweep after reset
	logic                  clr_active_q;
	logic [PIXEL_BITS-1:0] clr_addr_q;

	// stage 1: item whose bin is being read
	logic                             valid_s1;
	phtc_pkg::cmd_t                   cmd_s1;
	logic [phtc_pkg::VALUE_BITS-1:0]  val_s1;
	logic [PIXEL_BITS-1:0]            idx_s1;

	// last ram write, for forwarding
	logic                  lw_valid_q;
	logic [PIXEL_BITS-1:0] lw_addr_q;
	logic [COUNT_BITS-1:0] lw_data_q;

	// output register
	logic              out_valid_q;
	phtc_pkg::result_t result_q;

	// ram ports
	logic                  ram_we;
	logic [PIXEL_BITS-1:0] ram_waddr;
	logic [COUNT_BITS-1:0] ram_wdata;
	logic [COUNT_BITS-1:0] ram_rdata;

	logic                  in_accept;
	logic                  s1_adv;
	logic [IDX_WIDE-1:0]   idx_wide;
	logic [PIXEL_BITS-1:0] in_idx;

	// stage 1 compute
	logic                  fwd_hit;
	logic [COUNT_BITS-1:0] old_count;
	logic [COUNT_BITS-1:0] new_count;
	logic [COUNT_BITS-1:0] res_count;
	logic [CNT_WIDE-1:0]   count_wide;
	logic                  item_we;
	logic [COUNT_BITS-1:0] item_wdata;
	logic                  item_bpx;
	logic                  item_oor;
	logic                  item_has_bar;
	logic [phtc_pkg::BAR_BITS-1:0] item_bar;
	phtc_pkg::result_t     item_res;

	assign cfg_ready = 1'b1;

	// register writes; an index past the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= phtc_pkg::THRESHOLD_RST;
			max_value_q <= phtc_pkg::MAX_VALUE_RST;
			bar_cap_q   <= phtc_pkg::BAR_CAP_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				phtc_pkg::CFG_THRESHOLD: threshold_q <= cfg_data;
				phtc_pkg::CFG_MAX_VALUE: max_value_q <= cfg_data;
				phtc_pkg::CFG_BAR_CAP:   bar_cap_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// s1 moves on when the output register is free or being emptied
	assign s1_adv        = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !clr_active_q && (!valid_s1 || s1_adv);
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	// bin index is the pixel value cut or widened to the bin count
	assign idx_wide = IDX_WIDE'(s_axis_tdata);
	assign in_idx   = idx_wide[PIXEL_BITS-1:0];

	// clearing sweep, one bin per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clr_active_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (&clr_addr_q) begin
				clr_active_q <= 1'b0;
			end
		end
	end

	// stage 1 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_s1 <= s_axis_tuser;
			val_s1 <= s_axis_tdata;
			idx_s1 <= in_idx;
		end
	end

	// the ram hands back pre-write data when the previous item hit the same bin
	assign fwd_hit   = lw_valid_q && (lw_addr_q == idx_s1);
	assign old_count = fwd_hit ? lw_data_q : ram_rdata;
	// saturating increment
	assign new_count = (&old_count) ? old_count : old_count + 1'b1;

	always_comb begin
		item_we      = 1'b0;
		item_wdata   = '0;
		item_bpx     = 1'b0;
		item_oor     = 1'b0;
		item_has_bar = 1'b0;
		res_count    = '0;
		case (cmd_s1)
			phtc_pkg::CMD_ACCUM: begin
				item_bpx = (val_s1 >= threshold_q);
				if (val_s1 > max_value_q) begin
					item_oor = 1'b1;
				end else begin
					item_we      = 1'b1;
					item_wdata   = new_count;
					res_count    = new_count;
					item_has_bar = 1'b1;
				end
			end
			phtc_pkg::CMD_READ: begin
				res_count    = old_count;
				item_has_bar = 1'b1;
			end
			phtc_pkg::CMD_CLEAR: begin
				item_we    = 1'b1;
				item_wdata = '0;
			end
			default: ;
		endcase
	end

	// bar is the count capped at bar_cap
	always_comb begin
		item_bar = '0;
		if (item_has_bar) begin
			if (res_count > COUNT_BITS'(bar_cap_q)) begin
				item_bar = bar_cap_q;
			end else begin
				item_bar = res_count[phtc_pkg::BAR_BITS-1:0];
			end
		end
	end

	assign count_wide = CNT_WIDE'(res_count);

	always_comb begin
		item_res              = '0;
		item_res.binary_pixel = item_bpx;
		item_res.bin_count    = count_wide[phtc_pkg::COUNT_OUT_BITS-1:0];
		item_res.bar_length   = item_bar;
		item_res.out_of_range = item_oor;
	end

	// write port shared by the sweep and the item write-back
	assign ram_we    = clr_active_q || (s1_adv && item_we);
	assign ram_waddr = clr_active_q ? clr_addr_q : idx_s1;
	assign ram_wdata = clr_active_q ? '0 : item_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_valid_q <= 1'b0;
		end else if (ram_we) begin
			lw_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			lw_addr_q <= ram_waddr;
			lw_data_q <= ram_wdata;
		end
	end

	phtc_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(NUM_BINS)
	) u_bins (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (in_accept),
		.raddr(in_idx),
		.rdata(ram_rdata)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			result_q <= item_res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = phtc_pkg::OUT_DATA_BITS'({result_q.bar_length,
		result_q.bin_count, result_q.binary_pixel});
	assign m_axis_tuser  = result_q.out_of_range;

	// no item enters while bins are still being zeroed
	`PHT_ASSERT_SAME(a_no_accept_in_sweep, clr_active_q, !s_axis_tready, "item taken during clear sweep")
	// a pixel above max_value never touches its bin
	`PHT_ASSERT_SAME(a_oor_no_write, s1_adv && item_oor, !item_we, "out of range pixel written back")
	// every accepted item reaches stage 1
	`PHT_ASSERT_NEXT(a_accept_to_s1, in_accept, valid_s1, "accepted item lost before stage 1")
	// every item leaving stage 1 shows up as a result
	`PHT_ASSERT_NEXT(a_s1_to_out, s1_adv, m_axis_tvalid, "item left stage 1 without a result")

endmodule

@@ sv/phtc_ram.sv @@
// generic single-write, single-read ram with registered read data
// read returns the old contents when the same entry is written in that cycle
// no dependencies
module phtc_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ tb/histogram_checker.sv @@
`timescale 1ns / 100ps
// result checker for the pixel histogram threshold core: keeps a shadow histogram and
// register set, predicts every result item and compares it on the output channel
// depends on phtc_pkg
module histogram_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	input  logic                               s_axis_tready,
	input  logic [phtc_pkg::VALUE_BITS-1:0]    s_axis_tdata,
	input  phtc_pkg::cmd_t                     s_axis_tuser,
	input  logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	input  logic [phtc_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
	input  logic                               m_axis_tuser,
	input  logic                               cfg_valid,
	input  logic                               cfg_ready,
	input  phtc_pkg::cfg_idx_t                 cfg_index,
	input  logic [phtc_pkg::CFG_BITS-1:0]      cfg_data,
	output int                                 fail_count,
	output int                                 results_due
);

	localparam logic [phtc_pkg::COUNT_OUT_BITS-1:0] COUNT_SAT = '1;

	logic [phtc_pkg::COUNT_OUT_BITS-1:0] shadow_bins [0:(1 << phtc_pkg::VALUE_BITS)-1];
	logic [phtc_pkg::CFG_BITS-1:0]       threshold;
	logic [phtc_pkg::CFG_BITS-1:0]       max_value;
	logic [phtc_pkg::CFG_BITS-1:0]       bar_cap;
	phtc_pkg::result_t                   due_q [$];

	function automatic logic [phtc_pkg::BAR_BITS-1:0] capped_bar(
			input logic [phtc_pkg::COUNT_OUT_BITS-1:0] cnt);
		return (cnt > phtc_pkg::COUNT_OUT_BITS'(bar_cap)) ? bar_cap :
			cnt[phtc_pkg::BAR_BITS-1:0];
	endfunction

	// applies one command to the shadow histogram and returns the result it gives
	function automatic phtc_pkg::result_t histogram_step(input phtc_pkg::cmd_t cmd,
			input logic [phtc_pkg::VALUE_BITS-1:0] v);
		phtc_pkg::result_t r;
		r = '0;
		case (cmd)
			phtc_pkg::CMD_ACCUM: begin
				r.binary_pixel = (v >= threshold);
				if (v > max_value) begin
					r.out_of_range = 1'b1;
				end else begin
					if (shadow_bins[v] != COUNT_SAT)
						shadow_bins[v] = shadow_bins[v] + 1'b1;
					r.bin_count  = shadow_bins[v];
					r.bar_length = capped_bar(shadow_bins[v]);
				end
			end
			phtc_pkg::CMD_READ: begin
				r.bin_count  = shadow_bins[v];
				r.bar_length = capped_bar(shadow_bins[v]);
			end
			phtc_pkg::CMD_CLEAR: begin
				shadow_bins[v] = '0;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		phtc_pkg::result_t want;
		phtc_pkg::result_t got;
		if (!arst_n) begin
			for (int i = 0; i < (1 << phtc_pkg::VALUE_BITS); i++)
				shadow_bins[i] = '0;
			threshold = phtc_pkg::THRESHOLD_RST;
			max_value = phtc_pkg::MAX_VALUE_RST;
			bar_cap   = phtc_pkg::BAR_CAP_RST;
			due_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					phtc_pkg::CFG_THRESHOLD: threshold = cfg_data;
					phtc_pkg::CFG_MAX_VALUE: max_value = cfg_data;
					phtc_pkg::CFG_BAR_CAP:   bar_cap   = cfg_data;
					default: begin
					end
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				due_q.push_back(histogram_step(s_axis_tuser, s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				if (due_q.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result item, expected none, actual tdata %h tuser %b",
						$time, m_axis_tdata, m_axis_tuser);
				end else begin
					want = due_q.pop_front();
					got  = phtc_pkg::result_t'({m_axis_tuser, m_axis_tdata[28:0]});
					check_field("binary_pixel", 32'(want.binary_pixel), 32'(got.binary_pixel));
					check_field("bin_count", 32'(want.bin_count), 32'(got.bin_count));
					check_field("bar_length", 32'(want.bar_length), 32'(got.bar_length));
					check_field("out_of_range", 32'(want.out_of_range), 32'(got.out_of_range));
				end
			end
		end
		results_due = due_q.size();
	end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// top of the pixel histogram threshold core testbench: clock, reset, stimulus and verdict
// depends on phtc_pkg, pixel_histogram_threshold_core and histogram_checker
module tb_top;

	// the fourth command code has no name in the package; the core answers it with zeros
	localparam phtc_pkg::cmd_t CMD_UNUSED = 2'd3;
	// slowest legal stall is the clearing sweep after reset or the receiver hold-off
	// below; the limit is several times either
	localparam int   WATCHDOG_LIMIT = 2000;
	localparam int   HOLD_CYCLES    = 200;
	localparam int   PHASES         = 8;
	localparam int   PHASE_ITEMS    = 120;

	logic                               clk           = 1'b0;
	logic                               arst_n        = 1'b0;
	logic                               s_axis_tvalid = 1'b0;
	logic                               s_axis_tready;
	logic [phtc_pkg::VALUE_BITS-1:0]    s_axis_tdata  = '0;   // [7:0] value
	phtc_pkg::cmd_t                     s_axis_tuser  = phtc_pkg::CMD_ACCUM;  // [1:0] cmd
	logic                               m_axis_tvalid;
	logic                               m_axis_tready = 1'b0;
	// [0] binary_pixel, [20:1] bin_count, [28:21] bar_length, [31:29] zero
	logic [phtc_pkg::OUT_DATA_BITS-1:0] m_axis_tdata;
	logic                               m_axis_tuser;   // [0] out_of_range
	logic                               cfg_valid     = 1'b0;
	logic                               cfg_ready;
	phtc_pkg::cfg_idx_t                 cfg_index     = phtc_pkg::CFG_THRESHOLD;
	logic [phtc_pkg::CFG_BITS-1:0]      cfg_data      = '0;

	int fail_count;
	int results_due;

	// idle rates in percent per cycle for each side
	int send_idle_pct = 0;
	int rcv_idle_pct  = 0;
	// receiver hold-off: a change of hold_req starts one long stall
	int hold_req      = 0;
	int hold_seen     = 0;
	int hold_left     = 0;
	int idle_cycles   = 0;

	always #1 clk = ~clk;

	pixel_histogram_threshold_core u_top (.*);

	histogram_checker u_checker (.*);

	// receiver: random stalls, plus one long hold-off counted here so the core backs up
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen     <= hold_req;
			hold_left     <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left     <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
		end
	end

	// watchdog on cycles in which no channel moves an item
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else if (arst_n)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL pixel_histogram_threshold_core");
			$finish;
		end
	end

	// offers one item after an optional random gap and returns at its accept edge;
	// valid is only lowered when a gap is taken, so back-to-back items keep it high
	task automatic send_item(input phtc_pkg::cmd_t cmd,
			input logic [phtc_pkg::VALUE_BITS-1:0] v);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < send_idle_pct)
			gap++;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= v;
		s_axis_tuser  <= cmd;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	// stops offering and waits until every predicted result has come back
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (results_due != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// writes all three registers; only called with the core idle
	task automatic write_config(input logic [phtc_pkg::CFG_BITS-1:0] th,
			input logic [phtc_pkg::CFG_BITS-1:0] mx,
			input logic [phtc_pkg::CFG_BITS-1:0] cap);
		phtc_pkg::cfg_idx_t            idx [3];
		logic [phtc_pkg::CFG_BITS-1:0] val [3];
		idx = '{phtc_pkg::CFG_THRESHOLD, phtc_pkg::CFG_MAX_VALUE, phtc_pkg::CFG_BAR_CAP};
		val = '{th, mx, cap};
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	// register setting with the extremes weighted up
	function automatic logic [phtc_pkg::CFG_BITS-1:0] pick_setting();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return '0;
		if (r < 35)
			return '1;
		return phtc_pkg::CFG_BITS'($urandom_range(0, 255));
	endfunction

	initial begin
		int                              r;
		int                              mode;
		phtc_pkg::cmd_t                  cmd;
		logic [phtc_pkg::VALUE_BITS-1:0] v;
		logic [phtc_pkg::VALUE_BITS-1:0] last_value;

		last_value = '0;
		repeat (6) @(posedge clk);
		arst_n        <= 1'b1;
		send_idle_pct  = 8;
		rcv_idle_pct  <= 49;

		// reset settings: threshold edges, same bin back to back, empty bin, clear
		send_item(phtc_pkg::CMD_ACCUM, 8'd0);
		send_item(phtc_pkg::CMD_ACCUM, 8'd127);
		send_item(phtc_pkg::CMD_ACCUM, 8'd128);
		send_item(phtc_pkg::CMD_ACCUM, 8'd255);
		send_item(phtc_pkg::CMD_ACCUM, 8'd255);
		send_item(phtc_pkg::CMD_READ, 8'd255);
		send_item(phtc_pkg::CMD_READ, 8'd1);
		send_item(phtc_pkg::CMD_CLEAR, 8'd255);
		send_item(phtc_pkg::CMD_READ, 8'd255);
		send_item(phtc_pkg::CMD_ACCUM, 8'd255);
		// unused command code leaves the histogram alone
		send_item(CMD_UNUSED, 8'hff);
		send_item(CMD_UNUSED, 8'h00);

		// all registers at zero: only pixel 0 is valid, every bar is empty,
		// reads and clears reach bins above max_value
		drain();
		write_config('0, '0, '0);
		send_item(phtc_pkg::CMD_ACCUM, 8'd0);
		send_item(phtc_pkg::CMD_ACCUM, 8'd1);
		send_item(phtc_pkg::CMD_ACCUM, 8'd255);
		send_item(phtc_pkg::CMD_READ, 8'd128);
		send_item(phtc_pkg::CMD_CLEAR, 8'd128);
		send_item(phtc_pkg::CMD_READ, 8'd0);

		// top threshold, top pixel flagged but still thresholded, widest bar
		drain();
		write_config('1, 8'd254, '1);
		send_item(phtc_pkg::CMD_ACCUM, 8'd255);
		send_item(phtc_pkg::CMD_ACCUM, 8'd254);
		send_item(phtc_pkg::CMD_READ, 8'd254);
		send_item(phtc_pkg::CMD_CLEAR, 8'd0);
		send_item(phtc_pkg::CMD_READ, 8'd0);

		// random phases: mostly accumulations on a few hot bins, so counts pass the
		// bar cap and the same bin often follows itself through the write-back path
		for (int p = 0; p < PHASES; p++) begin
			drain();
			write_config(pick_setting(), pick_setting(), pick_setting());
			mode = p * 3 / PHASES;
			send_idle_pct = (mode == 0) ? 8 : (mode == 1) ? 49 : 0;
			rcv_idle_pct <= (mode == 0) ? 49 : (mode == 1) ? 8 : 0;
			// one long receiver stall while the sender keeps offering
			if (p == 1)
				hold_req <= hold_req + 1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				r = $urandom_range(0, 99);
				cmd = (r < 62) ? phtc_pkg::CMD_ACCUM : (r < 82) ? phtc_pkg::CMD_READ :
					(r < 93) ? phtc_pkg::CMD_CLEAR : CMD_UNUSED;
				r = $urandom_range(0, 99);
				if (r < 30)
					v = last_value;
				else if (r < 60)
					v = phtc_pkg::VALUE_BITS'($urandom_range(0, 7));
				else
					v = phtc_pkg::VALUE_BITS'($urandom_range(0, 255));
				last_value = v;
				send_item(cmd, v);
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("PASS pixel_histogram_threshold_core");
		else
			$display("FAIL pixel_histogram_threshold_core");
		$finish;
	end

endmodule
